// ===== rtl/crc8lpd_pkg.sv =====
// ----------------------------------------------------------------------------
// crc8lpd_pkg
// Shared types, constants and the CRC-8 byte update for the length-prefixed
// frame decoder.
// ----------------------------------------------------------------------------
package crc8lpd_pkg;

   localparam int unsigned STORE_DEPTH = 16;
   localparam int unsigned STORE_AW    = $clog2(STORE_DEPTH);

   localparam logic [7:0] LEN_MIN          = 8'd2;
   localparam logic [7:0] MAX_LENGTH_FIELD = 8'd18;
   localparam logic [7:0] HARD_MAX_LENGTH  = 8'd18;   // store holds 16 payload bytes
   localparam logic [7:0] COUNT_MAX        = 8'd255;
   localparam logic [7:0] CRC_POLY         = 8'h07;
   localparam logic [4:0] MIN_FRAME_RESET  = 5'd3;

   typedef enum logic [1:0] {
      DEC_OK      = 2'd0,
      DEC_BAD_LEN = 2'd1,
      DEC_BAD_CRC = 2'd2
   } dec_status_type;

   typedef enum logic [1:0] {
      OUT_BAD_LEN,
      OUT_BAD_CRC,
      OUT_OK_EMPTY,
      OUT_OK_PAYLOAD
   } out_kind_type;

   typedef enum logic [1:0] {
      S_ACCEPT,
      S_CHECK,
      S_READ,
      S_LOAD
   } state_type;

   typedef struct packed {
      logic         byte_take;
      logic         frame_clear;
      logic         load_out;
      out_kind_type kind;
      logic         rd_en;
      logic         idx_clear;
      logic         idx_inc;
   } dp_cmd_type;

   typedef struct packed {
      logic bad_len;
      logic bad_crc;
      logic cnt_zero;
      logic idx_last;
      logic out_free;
   } dp_sts_type;

   // CRC-8/SMBus: poly 0x07, MSB first, no reflection
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ===== rtl/crc8_length_prefixed_frame_decoder_core.sv =====
// ----------------------------------------------------------------------------
// crc8_length_prefixed_frame_decoder_core
// CRC-8/SMBus length-prefixed frame decoder, top level.
// ----------------------------------------------------------------------------
// Usage:
//  - req_* carries one received byte per transfer; req_buffer_end marks the
//    last byte of a buffer. Bytes are taken one per cycle while a buffer is
//    being gathered.
//  - After the end byte the block runs the length/CRC check in the check
//    state (req_ready low). A bad-length, bad-CRC or empty-payload frame gives
//    one result, loaded from the check state once the result register is free.
//  - A good frame with N payload bytes gives N results, each through a store
//    read and then a load of the result register, which waits while the
//    register is full; req_ready stays low until the last one is loaded.
//  - rsp_* is a registered output. A stalled receiver holds the result in
//    place; bytes of the next buffer keep being taken while a single result
//    waits, and the next result load waits for the register to free up.
//  - csr_* writes min_frame_bytes; always ready, write only while idle.
//  - Synchronous reset empties the result register, clears the frame state
//    and sets min_frame_bytes to 3.
// ----------------------------------------------------------------------------
module crc8_length_prefixed_frame_decoder_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [4:0] csr_wdata,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   input  logic       req_buffer_end,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_decode_status,
   output logic [7:0] rsp_frame_status,
   output logic [4:0] rsp_payload_count,
   output logic [3:0] rsp_payload_index,
   output logic [7:0] rsp_payload_data,
   output logic       rsp_payload_present,
   output logic       rsp_run_last
);

   crc8lpd_pkg::dp_cmd_type cmd;
   crc8lpd_pkg::dp_sts_type sts;

   assign csr_ready = 1'b1;

   crc8lpd_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_buffer_end (req_buffer_end),
      .req_ready      (req_ready),
      .sts            (sts),
      .cmd            (cmd)
   );

   crc8lpd_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_wdata           (csr_wdata),
      .req_rx_byte         (req_rx_byte),
      .cmd                 (cmd),
      .sts                 (sts),
      .rsp_ready           (rsp_ready),
      .rsp_valid           (rsp_valid),
      .rsp_decode_status   (rsp_decode_status),
      .rsp_frame_status    (rsp_frame_status),
      .rsp_payload_count   (rsp_payload_count),
      .rsp_payload_index   (rsp_payload_index),
      .rsp_payload_data    (rsp_payload_data),
      .rsp_payload_present (rsp_payload_present),
      .rsp_run_last        (rsp_run_last)
   );

endmodule

// ===== rtl/crc8lpd_ram.sv =====
// ----------------------------------------------------------------------------
// crc8lpd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module crc8lpd_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/crc8lpd_dp.sv =====
// ----------------------------------------------------------------------------
// crc8lpd_dp
// Datapath: per-byte frame state, CRC accumulator, payload store, verdict
// logic and the result output register.
// ----------------------------------------------------------------------------
module crc8lpd_dp (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_valid,
   input  logic [4:0]              csr_wdata,
   input  logic [7:0]              req_rx_byte,
   input  crc8lpd_pkg::dp_cmd_type cmd,
   output crc8lpd_pkg::dp_sts_type sts,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output logic [1:0]              rsp_decode_status,
   output logic [7:0]              rsp_frame_status,
   output logic [4:0]              rsp_payload_count,
   output logic [3:0]              rsp_payload_index,
   output logic [7:0]              rsp_payload_data,
   output logic                    rsp_payload_present,
   output logic                    rsp_run_last
);

   logic [4:0] min_ff, min_in;
   logic [7:0] count_ff, count_in;
   logic [7:0] len_ff, len_in;
   logic [7:0] crc_ff, crc_in;
   logic       match_ff, match_in;
   logic [7:0] stat_ff, stat_in;
   logic [crc8lpd_pkg::STORE_AW-1:0] idx_ff, idx_in;

   logic       valid_ff, valid_in;
   logic [1:0] o_status_ff, o_status_in;
   logic [7:0] o_frame_ff, o_frame_in;
   logic [4:0] o_count_ff, o_count_in;
   logic [3:0] o_index_ff, o_index_in;
   logic [7:0] o_data_ff, o_data_in;
   logic       o_present_ff, o_present_in;
   logic       o_last_ff, o_last_in;

   logic       st_wr_en;
   logic [crc8lpd_pkg::STORE_AW-1:0] st_wr_addr;
   logic [7:0] st_rd_data;
   logic [7:0] store_off;
   logic [4:0] pay_cnt;
   logic [8:0] len_plus1;

   // ---------------- per-byte frame state ----------------
   assign store_off  = count_ff - crc8lpd_pkg::LEN_MIN;
   assign st_wr_en   = cmd.byte_take && (count_ff >= crc8lpd_pkg::LEN_MIN)
                       && (store_off < 8'(crc8lpd_pkg::STORE_DEPTH));
   assign st_wr_addr = store_off[crc8lpd_pkg::STORE_AW-1:0];

   always_comb begin
      min_in   = min_ff;
      count_in = count_ff;
      len_in   = len_ff;
      crc_in   = crc_ff;
      match_in = match_ff;
      stat_in  = stat_ff;
      if (csr_valid) begin
         min_in = csr_wdata;
      end
      if (cmd.frame_clear) begin
         count_in = '0;
         len_in   = '0;
         crc_in   = '0;
         match_in = 1'b0;
         stat_in  = '0;
      end else if (cmd.byte_take) begin
         if (count_ff == 8'd0) begin
            len_in = req_rx_byte;
            crc_in = crc8lpd_pkg::crc8_byte(8'h00, req_rx_byte);
         end else begin
            if (count_ff == 8'd1) begin
               stat_in = req_rx_byte;
            end
            if (count_ff < len_ff) begin
               crc_in = crc8lpd_pkg::crc8_byte(crc_ff, req_rx_byte);
            end else if (count_ff == len_ff) begin
               match_in = (crc_ff == req_rx_byte);
            end
         end
         if (count_ff != crc8lpd_pkg::COUNT_MAX) begin
            count_in = count_ff + 8'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff   <= crc8lpd_pkg::MIN_FRAME_RESET;
         count_ff <= '0;
         len_ff   <= '0;
         crc_ff   <= '0;
         match_ff <= 1'b0;
         stat_ff  <= '0;
      end else begin
         min_ff   <= min_in;
         count_ff <= count_in;
         len_ff   <= len_in;
         crc_ff   <= crc_in;
         match_ff <= match_in;
         stat_ff  <= stat_in;
      end
   end

   crc8lpd_ram #(
      .WIDTH (8),
      .DEPTH (crc8lpd_pkg::STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (req_rx_byte),
      .rd_en   (cmd.rd_en),
      .rd_addr (idx_ff),
      .rd_data (st_rd_data)
   );

   // ---------------- verdict ----------------
   assign len_plus1 = {1'b0, len_ff} + 9'd1;
   assign pay_cnt   = 5'(len_ff - crc8lpd_pkg::LEN_MIN);

   assign sts.bad_len  = (count_ff < {3'b000, min_ff})
                         || (len_ff < crc8lpd_pkg::LEN_MIN)
                         || (len_ff > crc8lpd_pkg::MAX_LENGTH_FIELD)
                         || (len_ff > crc8lpd_pkg::HARD_MAX_LENGTH)
                         || ({1'b0, count_ff} < len_plus1);
   assign sts.bad_crc  = !match_ff;
   assign sts.cnt_zero = (pay_cnt == 5'd0);
   assign sts.idx_last = (({1'b0, idx_ff} + 5'd1) == pay_cnt);
   assign sts.out_free = !valid_ff || rsp_ready;

   // ---------------- payload index ----------------
   always_comb begin
      idx_in = idx_ff;
      if (cmd.idx_clear) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   // ---------------- result register ----------------
   always_comb begin
      valid_in     = valid_ff;
      o_status_in  = o_status_ff;
      o_frame_in   = o_frame_ff;
      o_count_in   = o_count_ff;
      o_index_in   = o_index_ff;
      o_data_in    = o_data_ff;
      o_present_in = o_present_ff;
      o_last_in    = o_last_ff;
      if (cmd.load_out) begin
         valid_in     = 1'b1;
         o_status_in  = crc8lpd_pkg::DEC_OK;
         o_frame_in   = stat_ff;
         o_count_in   = '0;
         o_index_in   = '0;
         o_data_in    = '0;
         o_present_in = 1'b0;
         o_last_in    = 1'b1;
         case (cmd.kind)
            crc8lpd_pkg::OUT_BAD_LEN: begin
               o_status_in = crc8lpd_pkg::DEC_BAD_LEN;
               o_frame_in  = '0;
            end
            crc8lpd_pkg::OUT_BAD_CRC: begin
               o_status_in = crc8lpd_pkg::DEC_BAD_CRC;
               o_frame_in  = '0;
            end
            crc8lpd_pkg::OUT_OK_PAYLOAD: begin
               o_count_in   = pay_cnt;
               o_index_in   = 4'(idx_ff);
               o_data_in    = st_rd_data;
               o_present_in = 1'b1;
               o_last_in    = sts.idx_last;
            end
            default: begin
               // empty payload: defaults above
            end
         endcase
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      o_status_ff  <= o_status_in;
      o_frame_ff   <= o_frame_in;
      o_count_ff   <= o_count_in;
      o_index_ff   <= o_index_in;
      o_data_ff    <= o_data_in;
      o_present_ff <= o_present_in;
      o_last_ff    <= o_last_in;
   end

   assign rsp_valid           = valid_ff;
   assign rsp_decode_status   = o_status_ff;
   assign rsp_frame_status    = o_frame_ff;
   assign rsp_payload_count   = o_count_ff;
   assign rsp_payload_index   = o_index_ff;
   assign rsp_payload_data    = o_data_ff;
   assign rsp_payload_present = o_present_ff;
   assign rsp_run_last        = o_last_ff;

endmodule

// ===== rtl/crc8lpd_ctrl.sv =====
// ----------------------------------------------------------------------------
// crc8lpd_ctrl
// Controller: takes bytes, runs the end-of-buffer check and sequences the
// payload readout from the store into the result register.
// ----------------------------------------------------------------------------
module crc8lpd_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_buffer_end,
   output logic                    req_ready,
   input  crc8lpd_pkg::dp_sts_type sts,
   output crc8lpd_pkg::dp_cmd_type cmd
);

   crc8lpd_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= crc8lpd_pkg::S_ACCEPT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      req_ready       = 1'b0;
      cmd.byte_take   = 1'b0;
      cmd.frame_clear = 1'b0;
      cmd.load_out    = 1'b0;
      cmd.kind        = crc8lpd_pkg::OUT_OK_EMPTY;
      cmd.rd_en       = 1'b0;
      cmd.idx_clear   = 1'b0;
      cmd.idx_inc     = 1'b0;
      case (state_ff)
         crc8lpd_pkg::S_ACCEPT: begin
            req_ready     = 1'b1;
            cmd.byte_take = req_valid;
            if (req_valid && req_buffer_end) begin
               state_in = crc8lpd_pkg::S_CHECK;
            end
         end
         crc8lpd_pkg::S_CHECK: begin
            if (!sts.bad_len && !sts.bad_crc && !sts.cnt_zero) begin
               cmd.idx_clear = 1'b1;
               state_in      = crc8lpd_pkg::S_READ;
            end else if (sts.out_free) begin
               // single-result frame
               cmd.load_out    = 1'b1;
               cmd.frame_clear = 1'b1;
               if (sts.bad_len) begin
                  cmd.kind = crc8lpd_pkg::OUT_BAD_LEN;
               end else if (sts.bad_crc) begin
                  cmd.kind = crc8lpd_pkg::OUT_BAD_CRC;
               end else begin
                  cmd.kind = crc8lpd_pkg::OUT_OK_EMPTY;
               end
               state_in = crc8lpd_pkg::S_ACCEPT;
            end
         end
         crc8lpd_pkg::S_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = crc8lpd_pkg::S_LOAD;
         end
         crc8lpd_pkg::S_LOAD: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               cmd.kind     = crc8lpd_pkg::OUT_OK_PAYLOAD;
               if (sts.idx_last) begin
                  cmd.frame_clear = 1'b1;
                  state_in        = crc8lpd_pkg::S_ACCEPT;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in    = crc8lpd_pkg::S_READ;
               end
            end
         end
         default: begin
            state_in = crc8lpd_pkg::S_ACCEPT;
         end
      endcase
   end

endmodule

// ===== rtl/crc8lpd_checker.sv =====
// ----------------------------------------------------------------------------
// crc8lpd_checker
// Port-level checks on the result channel of the frame decoder.
// ----------------------------------------------------------------------------
module crc8lpd_port_checks (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_decode_status,
   input logic [7:0] rsp_frame_status,
   input logic [4:0] rsp_payload_count,
   input logic [3:0] rsp_payload_index,
   input logic [7:0] rsp_payload_data,
   input logic       rsp_payload_present,
   input logic       rsp_run_last
);

   // nothing is pending right after reset
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

   // failed frames give exactly one bare result
   a_fail_single : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_decode_status != crc8lpd_pkg::DEC_OK) |->
         rsp_run_last && !rsp_payload_present && (rsp_frame_status == 8'd0)
         && (rsp_payload_count == 5'd0))
      else $error("failed frame result carries payload fields");

   // payload bytes only on ok frames, index inside the count
   a_payload_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload_present |->
         (rsp_decode_status == crc8lpd_pkg::DEC_OK)
         && ({1'b0, rsp_payload_index} < rsp_payload_count)
         && (rsp_run_last == (({1'b0, rsp_payload_index} + 5'd1) == rsp_payload_count)))
      else $error("payload index out of range or wrong last flag");

   // stalled result holds
   a_stall_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_payload_data) && $stable(rsp_payload_index)
         && $stable(rsp_decode_status) && $stable(rsp_run_last))
      else $error("result changed while stalled");

endmodule

bind crc8_length_prefixed_frame_decoder_core crc8lpd_port_checks u_crc8lpd_port_checks (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_decode_status   (rsp_decode_status),
   .rsp_frame_status    (rsp_frame_status),
   .rsp_payload_count   (rsp_payload_count),
   .rsp_payload_index   (rsp_payload_index),
   .rsp_payload_data    (rsp_payload_data),
   .rsp_payload_present (rsp_payload_present),
   .rsp_run_last        (rsp_run_last)
);
